/* rtl/lrip_pkg.sv */
// lrip_pkg: shared types, codes and constants of the lidar range image projection
// depends on nothing; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package lrip_pkg;

	localparam int DEPTH_W      = 18;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 18'h3FFFF;
	localparam int ANG_W        = 18;
	localparam int CORDIC_STEPS = 16;
	localparam int ROW_SPLIT    = 32;
	localparam int QUARTER_TURN = 16384;
	localparam int HALF_TURN    = 32768;

	// row centres in micro-degrees
	localparam int ROW_TOP_UDEG   = 2000000;
	localparam int ROW_STEP_UDEG  = 333330;
	localparam int ROW_LOW_UDEG   = -8830000;
	localparam int ROW_STEP2_UDEG = 500000;
	localparam int UDEG_PER_TURN  = 360000000;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 10;
	localparam logic [CFG_IW-1:0] CFG_MIN_RANGE     = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_CLEAR_ON_READ = 2'd1;

	typedef enum logic [1:0] {
		ST_PLACED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_READ    = 2'd2
	} status_t;

	typedef struct packed {
		logic rdy;
		logic sq;
		logic root_start;
		logic root_step;
		logic root_h;
		logic cor_init;
		logic cor_step;
		logic cor_az;
		logic srch_init;
		logic srch_step;
		logic idx;
		logic upd;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_op;
		logic drop;
		logic out_busy;
	} sts_t;

	// atan(2^-i) in 2^-16 turn
	function automatic logic [ANG_W-1:0] cordic_atan(input logic [3:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			4'd0:    a = 18'd8192;
			4'd1:    a = 18'd4836;
			4'd2:    a = 18'd2555;
			4'd3:    a = 18'd1297;
			4'd4:    a = 18'd651;
			4'd5:    a = 18'd326;
			4'd6:    a = 18'd163;
			4'd7:    a = 18'd81;
			4'd8:    a = 18'd41;
			4'd9:    a = 18'd20;
			4'd10:   a = 18'd10;
			4'd11:   a = 18'd5;
			4'd12:   a = 18'd3;
			4'd13:   a = 18'd1;
			4'd14:   a = 18'd1;
			default: a = 18'd0;
		endcase
		return a;
	endfunction

endpackage

/* rtl/lrip_if.sv */
// lrip_if: valid/ready channels of the projection block (points, pixels, config writes)
// depends on nothing
`timescale 1ns / 1ps

interface lrip_point_if #(parameter int COORD_BITS = 18);
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic [5:0]                   read_row;
	logic [9:0]                   read_col;

	modport source (output valid, op, point_x, point_y, point_z, read_row, read_col,
		input ready);
	modport sink (input valid, op, point_x, point_y, point_z, read_row, read_col,
		output ready);
endinterface

interface lrip_pixel_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  pixel_row;
	logic [9:0]  pixel_col;
	logic [17:0] depth;

	modport source (output valid, status, pixel_row, pixel_col, depth, input ready);
	modport sink (input valid, status, pixel_row, pixel_col, depth, output ready);
endinterface

interface lrip_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lrip_ram.sv */
// lrip_ram: generic single write port ram with one registered read port
// depends on nothing
`timescale 1ns / 1ps

module lrip_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lrip_ctrl.sv */
// lrip_ctrl: sequencer of the projection block, drives the datapath by command beats
// depends on lrip_pkg
`timescale 1ns / 1ps

module lrip_ctrl #(
	parameter int ROWS = 64,
	parameter int COORD_BITS = 18,
	parameter int CNTW = 16,
	parameter int DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lrip_pkg::sts_t sts,
	output lrip_pkg::cmd_t cmd,
	output logic [CNTW-1:0] step
);
	import lrip_pkg::*;

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_SQ    = 14'b00000000000100,
		S_ROOTR = 14'b00000000001000,
		S_ROOTH = 14'b00000000010000,
		S_EINIT = 14'b00000000100000,
		S_ECOR  = 14'b00000001000000,
		S_AINIT = 14'b00000010000000,
		S_ACOR  = 14'b00000100000000,
		S_SINIT = 14'b00001000000000,
		S_SRCH  = 14'b00010000000000,
		S_IDX   = 14'b00100000000000,
		S_RD    = 14'b01000000000000,
		S_UPD   = 14'b10000000000000
	} state_t;

	localparam logic [CNTW-1:0] LAST_ENTRY = CNTW'(DEPTH - 1);
	localparam logic [CNTW-1:0] LAST_ROOT  = CNTW'(COORD_BITS);
	localparam logic [CNTW-1:0] LAST_COR   = CNTW'(CORDIC_STEPS - 1);
	localparam logic [CNTW-1:0] LAST_ROW   = CNTW'(ROWS - 1);
	localparam logic [CNTW-1:0] LAST_SQ    = CNTW'(2);

	state_t st_q, nxt;
	logic [CNTW-1:0] cnt_q;

	assign step = cnt_q;

	always_comb begin
		nxt = st_q;
		cmd = '0;
		unique case (st_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (cnt_q == LAST_ENTRY) nxt = S_IDLE;
			end
			S_IDLE: begin
				cmd.rdy = 1'b1;
				if (sts.in_valid) nxt = sts.in_op ? S_IDX : S_SQ;
			end
			S_SQ: begin
				cmd.sq = 1'b1;
				if (cnt_q == LAST_SQ) nxt = S_ROOTR;
			end
			S_ROOTR: begin
				if (cnt_q == '0) cmd.root_start = 1'b1;
				else cmd.root_step = 1'b1;
				if (cnt_q == LAST_ROOT) nxt = S_ROOTH;
			end
			S_ROOTH: begin
				cmd.root_h = 1'b1;
				if (cnt_q == '0) begin
					cmd.root_start = 1'b1;
					if (sts.drop) nxt = S_UPD;
				end else begin
					cmd.root_step = 1'b1;
					if (cnt_q == LAST_ROOT) nxt = S_EINIT;
				end
			end
			S_EINIT: begin
				cmd.cor_init = 1'b1;
				nxt = S_ECOR;
			end
			S_ECOR: begin
				cmd.cor_step = 1'b1;
				if (cnt_q == LAST_COR) nxt = S_AINIT;
			end
			S_AINIT: begin
				cmd.cor_init = 1'b1;
				cmd.cor_az = 1'b1;
				nxt = S_ACOR;
			end
			S_ACOR: begin
				cmd.cor_step = 1'b1;
				if (cnt_q == LAST_COR) nxt = S_SINIT;
			end
			S_SINIT: begin
				cmd.srch_init = 1'b1;
				nxt = S_SRCH;
			end
			S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (cnt_q == LAST_ROW) nxt = S_IDX;
			end
			S_IDX: begin
				cmd.idx = 1'b1;
				nxt = S_RD;
			end
			S_RD: begin
				nxt = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (!sts.out_busy) nxt = S_IDLE;
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			cnt_q <= '0;
		end else begin
			st_q <= nxt;
			if (nxt != st_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
		end
	end

	a_srch_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SRCH && cnt_q == LAST_ROW) |=> st_q == S_IDX)
		else $error("row search did not end after the last row");

	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(st_q == S_CLEAR) |-> $past(cnt_q) == LAST_ENTRY)
		else $error("clearing pass left early");

	a_upd_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_UPD && !sts.out_busy) |=> st_q == S_IDLE)
		else $error("result beat not retired");

endmodule

/* rtl/lrip_dp.sv */
// lrip_dp: datapath of the projection block: squares, root, cordic, binning, image store
// depends on lrip_pkg, lrip_if and lrip_ram
`timescale 1ns / 1ps

module lrip_dp #(
	parameter int ROWS = 64,
	parameter int COLS = 870,
	parameter int COORD_BITS = 18,
	parameter int CNTW = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lrip_pkg::cmd_t cmd,
	input  logic [CNTW-1:0] step,
	output lrip_pkg::sts_t sts,
	lrip_point_if.sink     point,
	lrip_pixel_if.source   pixel,
	lrip_cfg_if.sink       cfg
);
	import lrip_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int SW    = 2 * CB;
	localparam int CW    = CB + 20;
	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RIW   = $clog2(ROWS);
	localparam int CIW   = $clog2(COLS);
	localparam int RXW   = (CB > DEPTH_W) ? CB : DEPTH_W;

	// config registers
	logic [9:0] min_range_q;
	logic       clear_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= 10'd10;
			clear_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MIN_RANGE:     min_range_q <= cfg.data;
				CFG_CLEAR_ON_READ: clear_q <= cfg.data[0];
				default:           ;
			endcase
		end
	end

	// input capture
	logic                 op_q;
	logic signed [CB-1:0] x_q, y_q, z_q;
	logic [5:0]           rr_q;
	logic [9:0]           rc_q;

	assign point.ready = cmd.rdy;

	always_ff @(posedge clk) begin
		if (cmd.rdy && point.valid) begin
			op_q <= point.op;
			x_q <= point.point_x;
			y_q <= point.point_y;
			z_q <= point.point_z;
			rr_q <= point.read_row;
			rc_q <= point.read_col;
		end
	end

	// squares, one per cycle
	logic signed [CB-1:0] sq_src;
	logic signed [SW-1:0] sq_p;
	logic [SW-1:0]        hsq_q, sum_q;

	always_comb begin
		case (step[1:0])
			2'd0:    sq_src = x_q;
			2'd1:    sq_src = y_q;
			default: sq_src = z_q;
		endcase
		sq_p = sq_src * sq_src;
	end

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			case (step[1:0])
				2'd0:    hsq_q <= $unsigned(sq_p);
				2'd1:    hsq_q <= hsq_q + $unsigned(sq_p);
				default: sum_q <= hsq_q + $unsigned(sq_p);
			endcase
		end
	end

	// integer square root, two radicand bits a cycle
	logic [SW-1:0] rn_q, rres_q, rbit_q, rsum;
	logic [CB-1:0] rng_q;
	logic          drop_q, drop_now;

	assign rsum = rres_q + rbit_q;
	assign drop_now = rres_q[CB-1:0] < CB'(min_range_q);

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			rn_q <= cmd.root_h ? hsq_q : sum_q;
			rres_q <= '0;
			rbit_q <= SW'(1) << (SW - 2);
			if (cmd.root_h) begin
				rng_q <= rres_q[CB-1:0];
				drop_q <= drop_now;
			end
		end else if (cmd.root_step) begin
			if (rn_q >= rsum) begin
				rn_q <= rn_q - rsum;
				rres_q <= (rres_q >> 1) + rbit_q;
			end else begin
				rres_q <= rres_q >> 1;
			end
			rbit_q <= rbit_q >> 2;
		end
	end

	// vectoring cordic, one rotation a cycle
	logic signed [CW-1:0]    cx_q, cy_q, ix, iy, sx, sy, xs, ys;
	logic signed [ANG_W-1:0] ang_q, elev_q, ang_v, atn;
	logic                    zv_q;

	always_comb begin
		ix = cmd.cor_az ? CW'(x_q) : CW'($signed({1'b0, rres_q[CB-1:0]}));
		iy = cmd.cor_az ? CW'(y_q) : CW'(z_q);
		sx = ix <<< 16;
		sy = iy <<< 16;
		xs = cx_q >>> step[3:0];
		ys = cy_q >>> step[3:0];
		atn = $signed(cordic_atan(step[3:0]));
		ang_v = zv_q ? '0 : ang_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.cor_init) begin
			zv_q <= (ix == '0) && (iy == '0);
			if (cmd.cor_az) elev_q <= ang_v;
			if (sx < 0) begin
				if (sy >= 0) begin
					cx_q <= sy;
					cy_q <= -sx;
					ang_q <= ANG_W'(QUARTER_TURN);
				end else begin
					cx_q <= -sy;
					cy_q <= sx;
					ang_q <= -ANG_W'(QUARTER_TURN);
				end
			end else begin
				cx_q <= sx;
				cy_q <= sy;
				ang_q <= '0;
			end
		end else if (cmd.cor_step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				ang_q <= ang_q + atn;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				ang_q <= ang_q - atn;
			end
		end
	end

	// row search over centres, column by scaling
	logic signed [47:0] amul_q;
	logic signed [31:0] centre_q;
	logic signed [49:0] cdiff;
	logic [48:0]        dabs, bestd_q;
	logic               bestv_q;
	logic [RIW-1:0]     best_q;
	logic [CIW-1:0]     col_q, col_n;
	logic signed [18:0] tcol;
	logic [17:0]        tu;
	logic [31:0]        kp;
	logic [15:0]        kk;

	always_comb begin
		cdiff = 50'(amul_q) - (50'(centre_q) <<< 16);
		dabs = cdiff[49] ? 49'(-cdiff) : cdiff[48:0];
		tcol = 19'(ang_v) + 19'sd32768;
		tu = tcol[18] ? '0 : tcol[17:0];
		kp = 32'(tu) * 32'(COLS) + 32'd32767;
		kk = kp[31:16];
		col_n = (kk > 16'(COLS - 1)) ? CIW'(COLS - 1) : kk[CIW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			amul_q <= 48'(elev_q) * 48'(UDEG_PER_TURN);
			centre_q <= 32'(ROW_TOP_UDEG);
			bestv_q <= 1'b0;
			best_q <= '0;
			col_q <= col_n;
		end else if (cmd.srch_step) begin
			if (!bestv_q || dabs < bestd_q) begin
				bestv_q <= 1'b1;
				bestd_q <= dabs;
				best_q <= step[RIW-1:0];
			end
			if (step < CNTW'(ROW_SPLIT - 1)) centre_q <= centre_q - 32'(ROW_STEP_UDEG);
			else if (step == CNTW'(ROW_SPLIT - 1)) centre_q <= 32'(ROW_LOW_UDEG);
			else centre_q <= centre_q - 32'(ROW_STEP2_UDEG);
		end
	end

	// pixel address
	logic [AW-1:0] idx_q;
	logic          inr_q;
	logic [31:0]   rs32, cs32, idx32;

	always_comb begin
		rs32 = op_q ? 32'(rr_q) : 32'(best_q);
		cs32 = op_q ? 32'(rc_q) : 32'(col_q);
		idx32 = rs32 * 32'(COLS) + cs32;
	end

	always_ff @(posedge clk) begin
		if (cmd.idx) begin
			idx_q <= idx32[AW-1:0];
			inr_q <= (32'(rr_q) < 32'(ROWS)) && (32'(rc_q) < 32'(COLS));
		end
	end

	// image store
	logic [RXW-1:0]     rng_x;
	logic [DEPTH_W-1:0] sat, rdata, ram_wdata;
	logic [AW-1:0]      ram_waddr;
	logic               ram_we, upd_go, wr_upd, ov_q;

	assign rng_x = RXW'(rng_q);
	assign sat = (rng_x > RXW'(DEPTH_MAX)) ? DEPTH_MAX : rng_x[DEPTH_W-1:0];
	assign upd_go = cmd.upd && !sts.out_busy;
	assign wr_upd = upd_go && (op_q ? (inr_q && clear_q) : (!drop_q && (sat > rdata)));
	assign ram_we = cmd.clr || wr_upd;
	assign ram_waddr = cmd.clr ? step[AW-1:0] : idx_q;
	assign ram_wdata = (cmd.clr || op_q) ? '0 : sat;

	lrip_ram #(.WIDTH(DEPTH_W), .DEPTH(DEPTH)) u_img (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// result register
	status_t            st_o_q;
	logic [5:0]         row_o_q;
	logic [9:0]         col_o_q;
	logic [DEPTH_W-1:0] dep_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (upd_go) begin
			ov_q <= 1'b1;
		end else if (pixel.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			if (op_q) begin
				st_o_q <= ST_READ;
				row_o_q <= rr_q;
				col_o_q <= rc_q;
				dep_o_q <= inr_q ? rdata : '0;
			end else if (drop_q) begin
				st_o_q <= ST_DROPPED;
				row_o_q <= '0;
				col_o_q <= '0;
				dep_o_q <= sat;
			end else begin
				st_o_q <= ST_PLACED;
				row_o_q <= 6'(best_q);
				col_o_q <= 10'(col_q);
				dep_o_q <= sat;
			end
		end
	end

	assign pixel.valid = ov_q;
	assign pixel.status = st_o_q;
	assign pixel.pixel_row = row_o_q;
	assign pixel.pixel_col = col_o_q;
	assign pixel.depth = dep_o_q;

	assign sts.in_valid = point.valid;
	assign sts.in_op = point.op;
	assign sts.drop = drop_now;
	assign sts.out_busy = ov_q && !pixel.ready;

	a_clr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> (ram_we && ram_wdata == '0))
		else $error("clearing pass wrote a nonzero word");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && !op_q && !drop_q) |-> (32'(best_q) < 32'(ROWS) && 32'(col_q) < 32'(COLS)))
		else $error("placed point outside the image");

endmodule

/* rtl/lidar_range_image_projection.sv */
// lidar range image projection: a point item runs through the squares, the shared root unit
// (range, then horizontal distance), the 16-step cordic and the row search; a dropped point
// ends after the range root, and a read item goes straight to the address and store steps.
// one item at a time, result held in an output register so the next item is taken while
// it waits. after reset a clearing pass over all ROWS*COLS words zeroes the image store;
// config writes are taken throughout
`timescale 1ns / 1ps

module lidar_range_image_projection #(
	parameter int ROWS = 64,
	parameter int COLS = 870,
	parameter int COORD_BITS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	lrip_point_if.sink   point,
	lrip_pixel_if.source pixel,
	lrip_cfg_if.sink     cfg
);
	import lrip_pkg::*;

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNTW  = (AW > 5) ? AW : 5;

	cmd_t            cmd;
	sts_t            sts;
	logic [CNTW-1:0] step;

	lrip_ctrl #(
		.ROWS(ROWS), .COORD_BITS(COORD_BITS), .CNTW(CNTW), .DEPTH(DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd),
		.step   (step)
	);

	lrip_dp #(
		.ROWS(ROWS), .COLS(COLS), .COORD_BITS(COORD_BITS), .CNTW(CNTW)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.step   (step),
		.sts    (sts),
		.point  (point),
		.pixel  (pixel),
		.cfg    (cfg)
	);

endmodule

/* tb/lidar_range_image_projection_tb.sv */
// lidar_range_image_projection_tb: drives points and pixel reads, checks every result beat
// against a behavioral projection model; depends on lrip_pkg, lrip_if and the top level
`timescale 1ns / 1ps

module lidar_range_image_projection_tb;
	import lrip_pkg::*;

	localparam int ROWS = 64;
	localparam int COLS = 870;
	localparam int CB = 18;

	typedef struct {
		logic op;
		logic signed [CB-1:0] x, y, z;
		logic [5:0] rrow;
		logic [9:0] rcol;
	} item_t;

	typedef struct {
		status_t st;
		logic [5:0] row;
		logic [9:0] col;
		logic [17:0] depth;
	} pix_t;

	logic clk = 0;
	logic arst_n = 0;
	always #2 clk = ~clk;

	lrip_point_if #(.COORD_BITS(CB)) point ();
	lrip_pixel_if pixel ();
	lrip_cfg_if cfg ();

	lidar_range_image_projection #(.ROWS(ROWS), .COLS(COLS), .COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .pixel(pixel.source), .cfg(cfg.sink)
	);

	logic [17:0] img [0:ROWS*COLS-1];
	logic [9:0] mdl_min_range;
	logic mdl_clear;
	item_t pending [$];
	pix_t expected_pix [$];
	int errors = 0;
	bit idle_off = 0;
	bit hold_sink = 0;
	int send_gap = 0, recv_gap = 0;
	int atan_lut [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

	function automatic longint asr_l(longint v, int s);
		return v < 0 ? -1 - ((-1 - v) >>> s) : (v >>> s);
	endfunction

	function automatic longint root_floor(longint n);
		longint res, b;
		res = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic longint vec_angle(longint x, longint y);
		longint a, t, xs, ys;
		a = 0;
		if (x == 0 && y == 0) return 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; a = QUARTER_TURN;
			end else begin
				x = -y; y = t; a = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = asr_l(x, i);
			ys = asr_l(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; a += atan_lut[i];
			end else begin
				x -= ys; y += xs; a -= atan_lut[i];
			end
		end
		return a;
	endfunction

	function automatic int elev_row(longint a);
		int best;
		longint bd, d, c;
		best = 0;
		bd = -1;
		for (int r = 0; r < ROWS; r++) begin
			c = r < ROW_SPLIT ? 64'(ROW_TOP_UDEG) - 64'(ROW_STEP_UDEG) * r
				: 64'(ROW_LOW_UDEG) - 64'(ROW_STEP2_UDEG) * (r - ROW_SPLIT);
			d = a * UDEG_PER_TURN - c * 65536;
			if (d < 0) d = -d;
			if (bd < 0 || d < bd) begin
				bd = d;
				best = r;
			end
		end
		return best;
	endfunction

	function automatic int azim_col(longint a);
		longint t, k;
		t = a + HALF_TURN;
		if (t < 0) t = 0;
		k = (t * COLS + 32767) / 65536;
		if (k > COLS - 1) k = COLS - 1;
		return int'(k);
	endfunction

	function automatic pix_t project(item_t it);
		pix_t p;
		longint x, y, z, hsq, rng, sat;
		int idx;
		int row_i, col_i;
		if (it.op) begin
			p.st = ST_READ;
			p.row = it.rrow;
			p.col = it.rcol;
			p.depth = '0;
			if (it.rrow < ROWS && it.rcol < COLS) begin
				idx = it.rrow * COLS + it.rcol;
				p.depth = img[idx];
				if (mdl_clear) img[idx] = '0;
			end
			return p;
		end
		x = it.x; y = it.y; z = it.z;
		hsq = x * x + y * y;
		rng = root_floor(hsq + z * z);
		sat = rng > 262143 ? 262143 : rng;
		p.depth = sat[17:0];
		if (rng < mdl_min_range) begin
			p.st = ST_DROPPED; p.row = '0; p.col = '0;
			return p;
		end
		p.st = ST_PLACED;
		row_i = elev_row(vec_angle(root_floor(hsq), z));
		col_i = azim_col(vec_angle(x, y));
		p.row = 6'(row_i);
		p.col = 10'(col_i);
		idx = row_i * COLS + col_i;
		if (sat > img[idx]) img[idx] = sat[17:0];
		return p;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point.valid <= 0;
			point.op <= 0;
			point.point_x <= 0;
			point.point_y <= 0;
			point.point_z <= 0;
			point.read_row <= 0;
			point.read_col <= 0;
			send_gap <= 0;
		end else begin
			if (!point.valid || point.ready) begin
				if (point.valid && point.ready) begin
					expected_pix.insert(expected_pix.size(), project(pending.pop_front()));
				end
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					point.valid <= 0;
				end else if (pending.size() > 0) begin
					if (!idle_off && $urandom_range(0, 15) == 0)
						send_gap <= $urandom_range(1, 12);
					point.valid <= 1;
					point.op <= pending[0].op;
					point.point_x <= pending[0].x;
					point.point_y <= pending[0].y;
					point.point_z <= pending[0].z;
					point.read_row <= pending[0].rrow;
					point.read_col <= pending[0].rcol;
				end else begin
					point.valid <= 0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		pix_t e;
		if (!arst_n) begin
			pixel.ready <= 0;
			recv_gap <= 0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				if (expected_pix.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_pix.pop_front();
					if (pixel.status !== e.st) begin
						$error("status exp %0d got %0d", e.st, pixel.status); errors++;
					end
					if (pixel.pixel_row !== e.row) begin
						$error("pixel_row exp %0d got %0d", e.row, pixel.pixel_row); errors++;
					end
					if (pixel.pixel_col !== e.col) begin
						$error("pixel_col exp %0d got %0d", e.col, pixel.pixel_col); errors++;
					end
					if (pixel.depth !== e.depth) begin
						$error("depth exp %0d got %0d", e.depth, pixel.depth); errors++;
					end
				end
			end
			if (hold_sink) begin
				pixel.ready <= 0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				pixel.ready <= 0;
			end else if (!idle_off && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(1, 12);
				pixel.ready <= 0;
			end else begin
				pixel.ready <= 1;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		@(posedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		if (idx == CFG_MIN_RANGE) mdl_min_range = val;
		else mdl_clear = val[0];
	endtask

	task automatic drain();
		while (pending.size() > 0 || point.valid || expected_pix.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic add_point(int x, int y, int z);
		item_t it;
		it.op = 0; it.x = CB'(x); it.y = CB'(y); it.z = CB'(z); it.rrow = '0; it.rcol = '0;
		pending.insert(pending.size(), it);
	endtask

	task automatic add_read(int r, int c);
		item_t it;
		it.op = 1; it.x = '0; it.y = '0; it.z = '0; it.rrow = 6'(r); it.rcol = 10'(c);
		pending.insert(pending.size(), it);
	endtask

	task automatic add_random(int n);
		int m;
		int x, y, z;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(0, 9);
			x = $urandom_range(0, 1) ? $signed($urandom_range(0, 262143) - 131072)
				: $signed($urandom_range(0, 4000)) - 2000;
			y = $urandom_range(0, 1) ? $signed($urandom_range(0, 262143) - 131072)
				: $signed($urandom_range(0, 4000)) - 2000;
			z = $signed($urandom_range(0, 2000)) - 1000;
			if (m < 2) z = $signed($urandom_range(0, 262143) - 131072);
			if (m < 6) add_point(x, y, z);
			else if (m < 8) add_read($urandom_range(0, 63), $urandom_range(0, 1023));
			else begin
				add_point(x, y, z);
				add_read($urandom_range(0, 63), $urandom_range(0, 869));
			end
		end
	endtask

	initial begin
		cfg.valid = 0;
		cfg.index = CFG_MIN_RANGE;
		cfg.data = '0;
		mdl_min_range = 10'd10;
		mdl_clear = 1;
		for (int i = 0; i < ROWS * COLS; i++) img[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		write_reg(CFG_MIN_RANGE, 10'd0);
		write_reg(CFG_CLEAR_ON_READ, 10'd0);
		add_point(0, 0, 0);
		add_point(131071, 0, 0);
		add_point(-131072, 0, 0);
		add_point(-131072, -1, 0);
		add_point(-131072, 1, 0);
		add_point(0, 131071, 131071);
		add_point(-131072, -131072, -131072);
		add_point(131071, 131071, 131071);
		add_point(1000, 0, 35);
		add_point(1000, 0, -400);
		add_point(1000, 0, -1000);
		add_point(0, -5000, 3);
		add_point(3, 4, 0);
		add_read(0, 435);
		add_read(0, 435);
		add_read(63, 869);
		add_read(63, 1023);
		add_read(0, 870);
		drain();
		write_reg(CFG_MIN_RANGE, 10'd1000);
		write_reg(CFG_CLEAR_ON_READ, 10'd1);
		add_point(600, 800, 0);
		add_point(600, 800, 1);
		add_point(999, 0, 0);
		add_read(0, 435);
		add_read(0, 435);
		drain();
		write_reg(CFG_MIN_RANGE, 10'd1023);
		add_random(80);
		drain();
		write_reg(CFG_MIN_RANGE, 10'($urandom_range(0, 1000)));
		write_reg(CFG_CLEAR_ON_READ, 10'd0);
		add_random(60);
		repeat (30) @(posedge clk);
		hold_sink = 1;
		repeat (2000) @(posedge clk);
		hold_sink = 0;
		drain();
		write_reg(CFG_MIN_RANGE, 10'd10);
		write_reg(CFG_CLEAR_ON_READ, 10'd1);
		add_random(280);
		while (pending.size() > 40) @(posedge clk);
		idle_off = 1;
		drain();
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
